// ===== rtl/rpc_pkg.sv =====
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants of the rectangular/polar converter
// Field widths, CORDIC datapath widths, the command and kind codes, the
// per-stage arctangent constants and the structs handed along the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package rpc_pkg;

	// Stage count and field fraction bits.
	localparam int CORDIC_STAGES = 24;
	localparam int FRAC_BITS = 16;

	// Internal formats: angles carry 32 fraction bits, coordinates 30 guard bits.
	localparam int ANG_FRAC = 32;
	localparam int GUARD = 30;

	// Port field widths.
	localparam int A_W = 24;
	localparam int B_W = 26;
	localparam int MAG_W = 25;
	localparam int ANG_W = 26;

	// Datapath widths: coordinates, angle accumulator, stage index.
	localparam int XW = 57;
	localparam int ZW = 42;
	localparam int SHW = $clog2(CORDIC_STAGES);

	// Width of the angle reduction arithmetic in field format.
	localparam int RW = (FRAC_BITS + 11 > B_W + 1) ? FRAC_BITS + 11 : B_W + 1;

	// CORDIC gain correction, 0.60725293501 in Q30.
	localparam logic [29:0] K_Q30 = 30'd652032874;

	// Command codes on the input channel.
	localparam logic [1:0] CMD_RECT = 2'd0;
	localparam logic [1:0] CMD_POLAR = 2'd1;

	typedef enum logic [1:0] {
		KIND_RECT,
		KIND_POLAR,
		KIND_BAD
	} kind_t;

	// Everything that rides along the row untouched by the rotation.
	typedef struct packed {
		kind_t             kind;
		logic              zero;
		logic [A_W-1:0]    echo_a;
		logic [B_W-1:0]    echo_b;
	} side_t;

	typedef struct packed {
		side_t                side;
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic signed [ZW-1:0] z;
	} cell_t;

	// atan(2^-i) in units of 1e-12 degree.
	localparam longint unsigned E12 = 64'd1000000000000;
	localparam longint unsigned ATAN_TAB [32] = '{
		64'd45000000000000, 64'd26565051177078, 64'd14036243467926, 64'd7125016348902,
		64'd3576334374997, 64'd1789910608246, 64'd895173710211, 64'd447614170861,
		64'd223810500369, 64'd111905677066, 64'd55952891894, 64'd27976452617,
		64'd13988227142, 64'd6994113675, 64'd3497056851, 64'd1748528427,
		64'd874264214, 64'd437132107, 64'd218566053, 64'd109283027,
		64'd54641513, 64'd27320757, 64'd13660378, 64'd6830189,
		64'd3415095, 64'd1707547, 64'd853774, 64'd426887,
		64'd213443, 64'd106722, 64'd53361, 64'd26680
	};

	// Stage constant in degrees with 32 fraction bits, rounded to nearest.
	// Only ever called with a constant stage index.
	function automatic logic [ZW-1:0] atan_q32(input int unsigned idx);
		longint unsigned v;
		longint unsigned q;
		longint unsigned r;
		longint unsigned a;
		longint unsigned r2;
		longint unsigned b;
		longint unsigned s;
		v = ATAN_TAB[idx[4:0]];
		q = v / E12;
		r = v % E12;
		a = (r << 16) / E12;
		r2 = (r << 16) % E12;
		b = ((r2 << 16) + E12 / 2) / E12;
		s = (q << 32) + (a << 16) + b;
		return s[ZW-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rpc_if.sv =====
// ----------------------------------------------------------------------------
// rpc_if: valid/ready channels of the rectangular/polar converter
// rpc_item_if carries one input vector, rpc_result_if one converted result.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpc_item_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     cmd;
	logic signed [rpc_pkg::A_W-1:0] coord_a;
	logic signed [rpc_pkg::B_W-1:0] coord_b;

	modport source (output valid, output cmd, output coord_a, output coord_b, input ready);
	modport sink (input valid, input cmd, input coord_a, input coord_b, output ready);
endinterface

interface rpc_result_if;
	logic                             valid;
	logic                             ready;
	logic signed [rpc_pkg::A_W-1:0]   x_out;
	logic signed [rpc_pkg::A_W-1:0]   y_out;
	logic signed [rpc_pkg::MAG_W-1:0] mag_out;
	logic signed [rpc_pkg::ANG_W-1:0] angle_out;
	logic                             mode_out;
	logic                             mode_error;

	modport source (output valid, output x_out, output y_out, output mag_out,
		output angle_out, output mode_out, output mode_error, input ready);
	modport sink (input valid, input x_out, input y_out, input mag_out,
		input angle_out, input mode_out, input mode_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/rpc_prep.sv =====
// ----------------------------------------------------------------------------
// rpc_prep: input stages of the converter
// Decodes the command, saturates y, reduces the polar angle to +-90 degrees
// and loads the scaled start vector for the CORDIC row (two pipeline stages).
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_prep (
	input  wire logic           clk,
	input  wire logic           arst_n,
	rpc_item_if.sink            item,
	output logic                down_valid,
	input  wire logic           down_ready,
	output rpc_pkg::cell_t      down_data
);

	localparam int A_W = rpc_pkg::A_W;
	localparam int B_W = rpc_pkg::B_W;
	localparam int RW = rpc_pkg::RW;
	localparam int XW = rpc_pkg::XW;
	localparam int ZW = rpc_pkg::ZW;
	localparam int ASH = rpc_pkg::ANG_FRAC - rpc_pkg::FRAC_BITS;

	localparam logic signed [B_W-1:0] Y_MAX = B_W'((longint'(1) <<< (A_W - 1)) - 1);
	localparam logic signed [B_W-1:0] Y_MIN = -B_W'(longint'(1) <<< (A_W - 1));
	localparam logic signed [RW-1:0] D90 = RW'(longint'(90) <<< rpc_pkg::FRAC_BITS);
	localparam logic signed [RW-1:0] D180 = RW'(longint'(180) <<< rpc_pkg::FRAC_BITS);
	localparam logic signed [RW-1:0] D360 = RW'(longint'(360) <<< rpc_pkg::FRAC_BITS);
	localparam logic signed [ZW-1:0] Z180 = ZW'(longint'(180) <<< rpc_pkg::ANG_FRAC);
	localparam logic signed [30:0] K_POS = {1'b0, rpc_pkg::K_Q30};

	// Stage 1 registers.
	logic                  valid_s1;
	rpc_pkg::kind_t        kind_s1;
	logic                  zero_s1;
	logic                  neg_s1;
	logic signed [A_W-1:0] a_s1;
	logic signed [A_W-1:0] yv_s1;
	logic signed [B_W-1:0] b_s1;
	logic signed [RW-1:0]  zf_s1;

	// Stage 2 registers.
	logic                  valid_s2;
	rpc_pkg::cell_t        data_s2;

	logic                  ready_s1;
	logic                  ready_s2;

	rpc_pkg::kind_t        kind_d;
	logic signed [A_W-1:0] yv_d;
	logic                  neg_d;
	logic signed [RW-1:0]  r0;
	logic signed [RW-1:0]  r1;
	logic signed [RW-1:0]  r2;
	logic signed [RW-1:0]  zf_d;
	logic                  turn_d;

	logic signed [A_W:0]   ax;
	logic signed [A_W:0]   ay;
	logic signed [30:0]    kmul;
	logic signed [A_W+30:0] pm;
	rpc_pkg::cell_t        data_d;

	assign ready_s2 = ~valid_s2 | down_ready;
	assign ready_s1 = ~valid_s1 | ready_s2;
	assign item.ready = ready_s1;
	assign down_valid = valid_s2;
	assign down_data = data_s2;

	always_comb begin
		case (item.cmd)
			rpc_pkg::CMD_RECT: kind_d = rpc_pkg::KIND_RECT;
			rpc_pkg::CMD_POLAR: kind_d = rpc_pkg::KIND_POLAR;
			default: kind_d = rpc_pkg::KIND_BAD;
		endcase

		if (item.coord_b > Y_MAX) begin
			yv_d = Y_MAX[A_W-1:0];
		end else if (item.coord_b < Y_MIN) begin
			yv_d = Y_MIN[A_W-1:0];
		end else begin
			yv_d = item.coord_b[A_W-1:0];
		end

		// Truncating modulo 360, then into (-180, 180], then into [-90, 90]
		// with a half turn that flips the start vector.
		r0 = RW'(item.coord_b);
		if (r0 >= D360) begin
			r1 = r0 - D360;
		end else if (r0 <= -D360) begin
			r1 = r0 + D360;
		end else begin
			r1 = r0;
		end
		if (r1 > D180) begin
			r2 = r1 - D360;
		end else if (r1 <= -D180) begin
			r2 = r1 + D360;
		end else begin
			r2 = r1;
		end
		if (r2 > D90) begin
			zf_d = r2 - D180;
			turn_d = 1'b1;
		end else if (r2 < -D90) begin
			zf_d = r2 + D180;
			turn_d = 1'b1;
		end else begin
			zf_d = r2;
			turn_d = 1'b0;
		end

		neg_d = (kind_d == rpc_pkg::KIND_RECT) ? item.coord_a[A_W-1] : turn_d;
	end

	always_comb begin
		ax = neg_s1 ? -(A_W+1)'(a_s1) : (A_W+1)'(a_s1);
		ay = neg_s1 ? -(A_W+1)'(yv_s1) : (A_W+1)'(yv_s1);
		kmul = neg_s1 ? -K_POS : K_POS;
		pm = (A_W+31)'(a_s1) * (A_W+31)'(kmul);

		data_d.side.kind = kind_s1;
		data_d.side.zero = zero_s1;
		data_d.side.echo_a = a_s1;
		data_d.side.echo_b = b_s1;
		data_d.x = '0;
		data_d.y = '0;
		data_d.z = '0;
		case (kind_s1)
			rpc_pkg::KIND_RECT: begin
				data_d.side.echo_b = B_W'(yv_s1);
				data_d.x = XW'(ax) <<< rpc_pkg::GUARD;
				data_d.y = XW'(ay) <<< rpc_pkg::GUARD;
				// A vector in the left half plane starts from a half turn.
				if (neg_s1) begin
					data_d.z = yv_s1[A_W-1] ? -Z180 : Z180;
				end
			end
			rpc_pkg::KIND_POLAR: begin
				data_d.x = XW'(pm);
				data_d.z = ZW'(zf_s1) <<< ASH;
			end
			default: begin
				data_d.side.echo_a = '0;
				data_d.side.echo_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= item.valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && item.valid) begin
			kind_s1 <= kind_d;
			zero_s1 <= (item.coord_a == '0) && (yv_d == '0);
			neg_s1 <= neg_d;
			a_s1 <= item.coord_a;
			yv_s1 <= yv_d;
			b_s1 <= item.coord_b;
			zf_s1 <= zf_d;
		end
		if (ready_s2 && valid_s1) begin
			data_s2 <= data_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rpc_cell.sv =====
// ----------------------------------------------------------------------------
// rpc_cell: one CORDIC micro-rotation
// Rotates the held vector by +-atan(2^-shift), steering on y when vectoring
// and on the residual angle when rotating, and passes it to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_cell (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              up_valid,
	output logic                                   up_ready,
	input  wire rpc_pkg::cell_t                    up_data,
	output logic                                   down_valid,
	input  wire logic                              down_ready,
	output rpc_pkg::cell_t                         down_data,
	input  wire logic [rpc_pkg::SHW-1:0]           shift,
	input  wire logic signed [rpc_pkg::ZW-1:0]     atan
);

	localparam int XW = rpc_pkg::XW;
	localparam int ZW = rpc_pkg::ZW;

	logic                 valid_q;
	rpc_pkg::cell_t       data_q;

	logic signed [XW-1:0] xin;
	logic signed [XW-1:0] yin;
	logic signed [ZW-1:0] zin;
	logic signed [XW-1:0] xs;
	logic signed [XW-1:0] ys;
	logic                 ccw;
	rpc_pkg::cell_t       nxt;

	assign up_ready = ~valid_q | down_ready;
	assign down_valid = valid_q;
	assign down_data = data_q;

	always_comb begin
		xin = $signed(up_data.x);
		yin = $signed(up_data.y);
		zin = $signed(up_data.z);
		xs = xin >>> shift;
		ys = yin >>> shift;
		// Vectoring drives y toward zero; rotation drives z toward zero.
		ccw = (up_data.side.kind == rpc_pkg::KIND_RECT) ? yin[XW-1] : ~zin[ZW-1];
		nxt.side = up_data.side;
		if (ccw) begin
			nxt.x = xin - ys;
			nxt.y = yin + xs;
			nxt.z = zin - atan;
		end else begin
			nxt.x = xin + ys;
			nxt.y = yin - xs;
			nxt.z = zin + atan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rpc_post.sv =====
// ----------------------------------------------------------------------------
// rpc_post: output stages of the converter
// Applies the gain correction to the magnitude, rounds and clamps the angle
// and the rotated coordinates, and selects the fields per mode into the
// output register (two pipeline stages).
// ----------------------------------------------------------------------------
`default_nettype none

module rpc_post (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           up_valid,
	output logic                up_ready,
	input  wire rpc_pkg::cell_t up_data,
	rpc_result_if.source        result
);

	localparam int A_W = rpc_pkg::A_W;
	localparam int MAG_W = rpc_pkg::MAG_W;
	localparam int ANG_W = rpc_pkg::ANG_W;
	localparam int XW = rpc_pkg::XW;
	localparam int ZW = rpc_pkg::ZW;
	localparam int GUARD = rpc_pkg::GUARD;
	localparam int ASH = rpc_pkg::ANG_FRAC - rpc_pkg::FRAC_BITS;
	localparam int MW = XW - 2 - (GUARD - 8);
	localparam int PW = MW + 30;
	localparam int QW = PW + 1 - (GUARD + 8);

	localparam logic signed [ZW-1:0] ZHALF = ZW'(longint'(1) <<< (ASH - 1));
	localparam logic signed [ZW-1:0] ALIM = ZW'(longint'(180) <<< rpc_pkg::FRAC_BITS);
	localparam logic signed [XW:0] XHALF = (XW+1)'(longint'(1) <<< (GUARD - 1));
	localparam logic signed [XW:0] C_MAX = (XW+1)'((longint'(1) <<< (A_W - 1)) - 1);
	localparam logic signed [XW:0] C_MIN = -(XW+1)'(longint'(1) <<< (A_W - 1));
	localparam logic [PW:0] PHALF = (PW+1)'(longint'(1) <<< (GUARD + 7));
	localparam logic [QW-1:0] MAG_MAX = QW'((longint'(1) <<< (MAG_W - 1)) - 1);

	// Stage 1 registers.
	logic                    valid_s1;
	rpc_pkg::side_t          side_s1;
	logic [PW-1:0]           prod_s1;
	logic signed [ANG_W-1:0] ang_s1;
	logic signed [A_W-1:0]   xr_s1;
	logic signed [A_W-1:0]   yr_s1;

	// Stage 2 registers: the output register.
	logic                    valid_s2;
	logic signed [A_W-1:0]   x_s2;
	logic signed [A_W-1:0]   y_s2;
	logic signed [MAG_W-1:0] mag_s2;
	logic signed [ANG_W-1:0] ang_s2;
	logic                    mode_s2;
	logic                    err_s2;

	logic                    ready_s2;
	logic [MW-1:0]           m;
	logic [PW-1:0]           prod;
	logic signed [ZW-1:0]    zsum;
	logic signed [ZW-1:0]    zr;
	logic signed [ANG_W-1:0] ang_d;
	logic [PW:0]             psum;
	logic [QW-1:0]           mq;
	logic [QW-1:0]           msat;

	logic signed [A_W-1:0]   x_d;
	logic signed [A_W-1:0]   y_d;
	logic signed [MAG_W-1:0] mag_d;
	logic signed [ANG_W-1:0] ang2_d;
	logic                    mode_d;
	logic                    err_d;

	// Round half up to the field LSB and clamp to the coordinate range.
	function automatic logic signed [A_W-1:0] round_sat(input logic signed [XW-1:0] v);
		logic signed [XW:0] s;
		logic signed [XW:0] q;
		s = (XW+1)'(v) + XHALF;
		q = s >>> GUARD;
		if (q > C_MAX) begin
			q = C_MAX;
		end else if (q < C_MIN) begin
			q = C_MIN;
		end
		return q[A_W-1:0];
	endfunction

	assign ready_s2 = ~valid_s2 | result.ready;
	assign up_ready = ~valid_s1 | ready_s2;

	assign result.valid = valid_s2;
	assign result.x_out = x_s2;
	assign result.y_out = y_s2;
	assign result.mag_out = mag_s2;
	assign result.angle_out = ang_s2;
	assign result.mode_out = mode_s2;
	assign result.mode_error = err_s2;

	always_comb begin
		// After vectoring x is never negative, so its sign bit and the bit below it are dropped.
		m = up_data.x[GUARD-8 +: MW];
		prod = PW'(m) * PW'(rpc_pkg::K_Q30);

		zsum = $signed(up_data.z) + ZHALF;
		zr = zsum >>> ASH;
		if (zr > ALIM) begin
			ang_d = ALIM[ANG_W-1:0];
		end else if (zr < -ALIM) begin
			ang_d = -ALIM[ANG_W-1:0];
		end else begin
			ang_d = zr[ANG_W-1:0];
		end
	end

	always_comb begin
		psum = {1'b0, prod_s1} + PHALF;
		mq = psum[PW:GUARD+8];
		msat = (mq > MAG_MAX) ? MAG_MAX : mq;

		x_d = '0;
		y_d = '0;
		mag_d = '0;
		ang2_d = '0;
		mode_d = 1'b0;
		err_d = 1'b0;
		case (side_s1.kind)
			rpc_pkg::KIND_RECT: begin
				x_d = side_s1.echo_a;
				y_d = side_s1.echo_b[A_W-1:0];
				if (!side_s1.zero) begin
					mag_d = msat[MAG_W-1:0];
					ang2_d = ang_s1;
				end
			end
			rpc_pkg::KIND_POLAR: begin
				x_d = xr_s1;
				y_d = yr_s1;
				mag_d = MAG_W'($signed(side_s1.echo_a));
				ang2_d = side_s1.echo_b;
				mode_d = 1'b1;
			end
			default: begin
				err_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (up_ready) begin
				valid_s1 <= up_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			side_s1 <= up_data.side;
			prod_s1 <= prod;
			ang_s1 <= ang_d;
			xr_s1 <= round_sat(up_data.x);
			yr_s1 <= round_sat(up_data.y);
		end
		if (ready_s2 && valid_s1) begin
			x_s2 <= x_d;
			y_s2 <= y_d;
			mag_s2 <= mag_d;
			ang_s2 <= ang2_d;
			mode_s2 <= mode_d;
			err_s2 <= err_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rect_polar_converter.sv =====
// ----------------------------------------------------------------------------
// rect_polar_converter: pipelined CORDIC rectangular/polar converter
// Rectangular input yields magnitude and angle in degrees; polar input yields
// x and y. Built as two input stages, a row of CORDIC cells and two output
// stages.
//
//   channel  | dir | beat payload
//   ---------+-----+--------------------------------------------------------
//   item     | in  | cmd, coord_a, coord_b
//   result   | out | x_out, y_out, mag_out, angle_out, mode_out, mode_error
//
// One beat is taken per cycle unless a stalled result has filled every stage;
// the row holds one cell per CORDIC stage.
// Every stage holds its own valid bit and takes a new beat when it is empty
// or its successor moves, so a stalled result blocks input only once every
// stage is full. Ready reaches item.ready combinationally along the stages.
// Reset empties all stages; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_polar_converter (
	input  wire logic    clk,
	input  wire logic    arst_n,
	rpc_item_if.sink     item,
	rpc_result_if.source result
);

	localparam int N = rpc_pkg::CORDIC_STAGES;
	localparam int SHW = rpc_pkg::SHW;
	localparam logic signed [rpc_pkg::ANG_W-1:0] ALIM =
		rpc_pkg::ANG_W'(longint'(180) <<< rpc_pkg::FRAC_BITS);

	logic [N:0]     cvalid;
	logic [N:0]     cready;
	rpc_pkg::cell_t cdata [N+1];

	rpc_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.down_valid (cvalid[0]),
		.down_ready (cready[0]),
		.down_data  (cdata[0])
	);

	for (genvar g = 0; g < N; g++) begin : g_cell
		rpc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.up_valid   (cvalid[g]),
			.up_ready   (cready[g]),
			.up_data    (cdata[g]),
			.down_valid (cvalid[g+1]),
			.down_ready (cready[g+1]),
			.down_data  (cdata[g+1]),
			.shift      (SHW'(g)),
			.atan       ($signed(rpc_pkg::atan_q32(g)))
		);
	end

	rpc_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (cvalid[N]),
		.up_ready (cready[N]),
		.up_data  (cdata[N]),
		.result   (result)
	);

	// The first cell refuses a beat only when the whole row behind it is full.
	a_no_bubble_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!cready[0] |-> &cvalid[N:1])
		else $error("cell row stalled while holding a bubble");

	a_bad_mode_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.mode_error |->
			result.x_out == '0 && result.y_out == '0 && result.mag_out == '0 &&
			result.angle_out == '0 && !result.mode_out)
		else $error("invalid mode result carries nonzero fields");

	a_zero_vector: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.mode_out && result.x_out == '0 && result.y_out == '0 |->
			result.mag_out == '0 && result.angle_out == '0)
		else $error("zero vector gave nonzero magnitude or angle");

	a_rect_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.mode_out |->
			result.angle_out <= ALIM && result.angle_out >= -ALIM &&
			!result.mag_out[rpc_pkg::MAG_W-1])
		else $error("rectangular result angle or magnitude out of range");

endmodule

`default_nettype wire
